@@ src/scp_pkg.sv @@
`timescale 1ns / 1ps

package scp_pkg;

    // Field widths of the channels
    localparam int ANGLE_W  = 32;
    localparam int RESULT_W = 32;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS = 26;
    localparam int WORK_FRAC       = 44;
    localparam int POLY_FRAC       = 28;
    localparam int X_SHIFT         = WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int XR_SHIFT        = WORK_FRAC - POLY_FRAC;

    // Working angle in Q44, wide enough for the whole input range
    localparam int X_W    = ANGLE_W + X_SHIFT;
    // Multiplier operands, product and the rounded product slice
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int RND_W  = 36;

    localparam logic signed [63:0] PI_Q44  = 64'sh0000_3243_F6A8_885A;
    localparam logic signed [63:0] TAU_Q44 = 64'sh0000_6487_ED51_10B4;

    localparam int COEF_LAST = 4;
    localparam int IDX_W     = 3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_ROUND,
        OP_MUL_SQ,
        OP_SQ,
        OP_MUL_P,
        OP_ADD_P,
        OP_MUL_X,
        OP_RESULT
    } scp_op_t;

    typedef struct packed {
        scp_op_t          op;
        logic [IDX_W-1:0] idx;
    } scp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic func_cos;
    } scp_stat_t;

    // Taylor coefficients in Q30, alternating signs
    function automatic logic signed [OPND_W-1:0] coef(input logic func_cos,
                                                      input logic [IDX_W-1:0] idx);
        logic signed [OPND_W-1:0] c;
        c = '0;
        if (func_cos)
        begin
            unique case (idx)
                3'd0:    c = 33'sd1073741824;
                3'd1:    c = -33'sd536870912;
                3'd2:    c = 33'sd44739243;
                3'd3:    c = -33'sd1491308;
                3'd4:    c = 33'sd26631;
                default: c = '0;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    c = 33'sd1073741824;
                3'd1:    c = -33'sd178956971;
                3'd2:    c = 33'sd8947849;
                3'd3:    c = -33'sd213044;
                3'd4:    c = 33'sd2959;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

@@ src/scp_req_if.sv @@
`timescale 1ns / 1ps

interface scp_req_if import scp_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output func, output angle, input ready);
    modport sink   (input valid, input func, input angle, output ready);
endinterface

@@ src/scp_rsp_if.sv @@
`timescale 1ns / 1ps

interface scp_rsp_if import scp_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

@@ src/scp_datapath.sv @@
`timescale 1ns / 1ps

module scp_datapath import scp_pkg::*; (
    input  logic                       clk,
    input  scp_cmd_t                   cmd,
    output scp_stat_t                  stat,
    input  logic                       func,
    input  logic signed [ANGLE_W-1:0]  angle,
    output logic signed [RESULT_W-1:0] result
);

    localparam logic signed [X_W-1:0]    PI_X   = X_W'(PI_Q44);
    localparam logic signed [X_W-1:0]    TAU_X  = X_W'(TAU_Q44);
    localparam logic signed [X_W-1:0]    X_HALF = X_W'(1) <<< (XR_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) <<< (POLY_FRAC - 1);
    localparam logic signed [RND_W-1:0]  R_MAX  = RND_W'(64'sh7FFF_FFFF);
    localparam logic signed [RND_W-1:0]  R_MIN  = -RND_W'(64'sh8000_0000);

    logic                       func_reg;
    logic signed [X_W-1:0]      x_reg;
    logic signed [ANGLE_W-1:0]  xr_reg;
    logic signed [OPND_W-1:0]   x2_reg;
    logic signed [OPND_W-1:0]   p_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [RESULT_W-1:0] result_reg;

    logic signed [X_W-1:0]      x_sum;
    logic signed [PROD_W-1:0]   prod_sum;
    logic signed [RND_W-1:0]    prod_rnd;
    logic signed [OPND_W-1:0]   mul_a;
    logic signed [OPND_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_out;
    logic signed [RND_W-1:0]    res_src;
    logic signed [RESULT_W-1:0] res_sat;
    logic                       above_pi;
    logic                       below_pi;

    assign above_pi = x_reg > PI_X;
    assign below_pi = x_reg < -PI_X;

    assign stat.in_range = !above_pi && !below_pi;
    assign stat.func_cos = func_reg;

    // Round the reduced Q44 angle to Q28
    assign x_sum = x_reg + X_HALF;

    // Round a Q56/Q58 product back by POLY_FRAC bits
    assign prod_sum = prod_reg + P_HALF;
    assign prod_rnd = prod_sum[POLY_FRAC +: RND_W];

    always_comb
    begin
        case (cmd.op)
            OP_MUL_SQ:
            begin
                mul_a = OPND_W'(xr_reg);
                mul_b = OPND_W'(xr_reg);
            end
            OP_MUL_X:
            begin
                mul_a = OPND_W'(xr_reg);
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = x2_reg;
                mul_b = p_reg;
            end
        endcase
    end

    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign res_src = func_reg ? RND_W'(p_reg) : prod_rnd;

    always_comb
    begin
        if (res_src > R_MAX)
            res_sat = RESULT_W'(R_MAX);
        else if (res_src < R_MIN)
            res_sat = RESULT_W'(R_MIN);
        else
            res_sat = RESULT_W'(res_src);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                x_reg    <= signed'({angle, {X_SHIFT{1'b0}}});
            end
            OP_REDUCE:
            begin
                if (above_pi)
                    x_reg <= x_reg - TAU_X;
                else if (below_pi)
                    x_reg <= x_reg + TAU_X;
            end
            OP_ROUND:
                xr_reg <= x_sum[XR_SHIFT +: ANGLE_W];
            OP_MUL_SQ, OP_MUL_P, OP_MUL_X:
                prod_reg <= mul_out;
            OP_SQ:
            begin
                x2_reg <= prod_rnd[OPND_W-1:0];
                p_reg  <= coef(func_reg, IDX_W'(COEF_LAST));
            end
            OP_ADD_P:
                p_reg <= coef(func_reg, cmd.idx) + prod_rnd[OPND_W-1:0];
            OP_RESULT:
                result_reg <= res_sat;
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

@@ src/scp_controller.sv @@
`timescale 1ns / 1ps

module scp_controller import scp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  scp_stat_t stat,
    output scp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_ROUND,
        S_SQ_MUL,
        S_SQ_ADD,
        S_P_MUL,
        S_P_ADD,
        S_X_MUL,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rsp_valid_reg;
    logic             slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cmd.idx = idx_reg;
        unique case (state_reg)
            S_IDLE:   cmd.op = req_valid ? OP_LOAD : OP_NONE;
            S_REDUCE: cmd.op = OP_REDUCE;
            S_ROUND:  cmd.op = OP_ROUND;
            S_SQ_MUL: cmd.op = OP_MUL_SQ;
            S_SQ_ADD: cmd.op = OP_SQ;
            S_P_MUL:  cmd.op = OP_MUL_P;
            S_P_ADD:  cmd.op = OP_ADD_P;
            S_X_MUL:  cmd.op = OP_MUL_X;
            S_DONE:   cmd.op = slot_free ? OP_RESULT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid with a new result, drop it once the last one is taken
            if (state_reg == S_DONE && slot_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (req_valid)
                        state_reg <= S_REDUCE;
                S_REDUCE:
                    if (stat.in_range)
                        state_reg <= S_ROUND;
                S_ROUND:
                    state_reg <= S_SQ_MUL;
                S_SQ_MUL:
                    state_reg <= S_SQ_ADD;
                S_SQ_ADD:
                begin
                    idx_reg   <= IDX_W'(COEF_LAST - 1);
                    state_reg <= S_P_MUL;
                end
                S_P_MUL:
                    state_reg <= S_P_ADD;
                S_P_ADD:
                begin
                    if (idx_reg == '0)
                        state_reg <= stat.func_cos ? S_DONE : S_X_MUL;
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_P_MUL;
                    end
                end
                S_X_MUL:
                    state_reg <= S_DONE;
                S_DONE:
                    if (slot_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/sine_cosine_polynomial_unit.sv @@
`timescale 1ns / 1ps

// Sine / cosine of a fixed-point angle by a Taylor polynomial, degree 9 for sine, 8 for cosine.
// Channels: req carries func (0 = sine, 1 = cosine) and angle (Q5.26 radians);
// rsp carries result (Q1.30). Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high.
// The block computes one item at a time. After a req transfer the angle is
// brought into [-pi, pi] by adding or subtracting 2*pi once per cycle, then
// one shared 33x33 multiplier runs the square, four Horner steps and, for
// sine, the final multiply by x. The square and each Horner step take a
// multiply state and an add state; the product by x is rounded straight
// into the result register. The number of 2*pi steps is 0 to 5 over the
// Q5.26 range. rsp valid rises and req ready returns on the same edge.
// The result sits in an output register: req is taken again while the last
// result still waits. If the receiver stalls, the next result holds in the
// datapath until the register drains, and req ready stays low meanwhile.
// Reset (rst_n low, asynchronous) returns to idle and drops any result.
module sine_cosine_polynomial_unit import scp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    scp_req_if.sink   req,
    scp_rsp_if.source rsp
);

    scp_cmd_t  cmd;
    scp_stat_t stat;
    logic      req_ready;
    logic      rsp_valid;

    // Sequence the item: reduction loop, multiply/add steps, result hand-off
    scp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the angle, the polynomial accumulator and the shared multiplier
    scp_datapath u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .stat   (stat),
        .func   (req.func),
        .angle  (req.angle),
        .result (rsp.result)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

@@ src/scp_checker.sv @@
`timescale 1ns / 1ps

module scp_checker import scp_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic signed [RESULT_W-1:0] rsp_result
);

    logic [1:0] pending_reg;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Count items taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (req_xfer && !rsp_xfer)
            pending_reg <= pending_reg + 1'b1;
        else if (rsp_xfer && !req_xfer)
            pending_reg <= pending_reg - 1'b1;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
        else $error("rsp dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("rsp valid with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items outstanding");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> !req_ready ##1 !req_ready ##1 !req_ready)
        else $error("req taken again during computation");

endmodule

bind sine_cosine_polynomial_unit scp_checker u_scp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_result (rsp.result)
);
